@@ sv/dga_pkg.sv @@
// shared widths, types and saturation helpers for the density gradient accumulator
package dga_pkg;

   localparam int VAL_W    = 32;
   localparam int FRAC_W   = 27;
   localparam int SUM_W    = 48;
   localparam int GAMMA_W  = 63;
   localparam int LANE_CNT = 4;

   localparam int PROD_W   = 2 * VAL_W;
   localparam int ROUND_W  = PROD_W - FRAC_W;
   localparam int MAG_W    = (GAMMA_W + FRAC_W) / 2;
   localparam int HI_W     = MAG_W - FRAC_W;

   // lane roles
   localparam int LANE_DEN = 0;
   localparam int LANE_GX  = 1;
   localparam int LANE_GY  = 2;
   localparam int LANE_GZ  = 3;

   localparam logic signed [PROD_W-1:0] HALF_LSB = PROD_W'(64'sd1 <<< (FRAC_W - 1));

   typedef struct packed {
      logic valid;
      logic last;
   } lane_ctl_type;

   typedef struct packed {
      logic signed [SUM_W-1:0] density;
      logic signed [SUM_W-1:0] grad_x;
      logic signed [SUM_W-1:0] grad_y;
      logic signed [SUM_W-1:0] grad_z;
      logic [GAMMA_W-1:0]      gamma;
   } result_type;

   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

   // accumulator plus one rounded product, clamped to the sum range
   function automatic logic signed [SUM_W-1:0] sat_acc(
      input logic signed [SUM_W-1:0]   acc,
      input logic signed [ROUND_W-1:0] inc);
      logic signed [SUM_W:0] wide;
      wide = (SUM_W+1)'(acc) + (SUM_W+1)'(inc);
      if (wide[SUM_W] != wide[SUM_W-1]) begin
         sat_acc = wide[SUM_W] ? SUM_MIN : SUM_MAX;
      end else begin
         sat_acc = wide[SUM_W-1:0];
      end
   endfunction

   // multiply by 2 (shift 1) or 4 (shift 2) with clamping
   function automatic logic signed [SUM_W-1:0] sat_scale2(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W:0] wide;
      wide = (SUM_W+1)'(v) <<< 1;
      if (wide[SUM_W] != wide[SUM_W-1]) begin
         sat_scale2 = wide[SUM_W] ? SUM_MIN : SUM_MAX;
      end else begin
         sat_scale2 = wide[SUM_W-1:0];
      end
   endfunction

   function automatic logic signed [SUM_W-1:0] sat_scale4(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W+1:0] wide;
      wide = (SUM_W+2)'(v) <<< 2;
      if (!(wide[SUM_W+1:SUM_W-1] == 3'b000 || wide[SUM_W+1:SUM_W-1] == 3'b111)) begin
         sat_scale4 = wide[SUM_W+1] ? SUM_MIN : SUM_MAX;
      end else begin
         sat_scale4 = wide[SUM_W-1:0];
      end
   endfunction

endpackage

@@ sv/dga_req_if.sv @@
// input channel: one basis-function item per handshake
interface dga_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [dga_pkg::VAL_W-1:0]    basis_value;
   logic signed [dga_pkg::VAL_W-1:0]    basis_grad_x;
   logic signed [dga_pkg::VAL_W-1:0]    basis_grad_y;
   logic signed [dga_pkg::VAL_W-1:0]    basis_grad_z;
   logic signed [dga_pkg::VAL_W-1:0]    matrix_product;
   logic                                last_basis;

   modport source (
      output valid, basis_value, basis_grad_x, basis_grad_y, basis_grad_z,
             matrix_product, last_basis,
      input  ready
   );
   modport sink (
      input  valid, basis_value, basis_grad_x, basis_grad_y, basis_grad_z,
             matrix_product, last_basis,
      output ready
   );
endinterface

@@ sv/dga_rsp_if.sv @@
// result channel: density, gradient and gamma of one grid point
interface dga_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [dga_pkg::SUM_W-1:0]    density;
   logic signed [dga_pkg::SUM_W-1:0]    density_grad_x;
   logic signed [dga_pkg::SUM_W-1:0]    density_grad_y;
   logic signed [dga_pkg::SUM_W-1:0]    density_grad_z;
   logic [dga_pkg::GAMMA_W-1:0]         grad_norm_sq;

   modport source (
      output valid, density, density_grad_x, density_grad_y, density_grad_z, grad_norm_sq,
      input  ready
   );
   modport sink (
      input  valid, density, density_grad_x, density_grad_y, density_grad_z, grad_norm_sq,
      output ready
   );
endinterface

@@ sv/dga_lane.sv @@
// one multiply-accumulate lane: registered product, rounding and saturating sum
module dga_lane (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                load,
   input  dga_pkg::lane_ctl_type               ctl,
   input  logic signed [dga_pkg::VAL_W-1:0]    operand,
   input  logic signed [dga_pkg::VAL_W-1:0]    weight,
   output logic signed [dga_pkg::SUM_W-1:0]    total
);

   logic signed [dga_pkg::PROD_W-1:0]  prod_ff;
   logic signed [dga_pkg::PROD_W-1:0]  prod_rnd;
   logic signed [dga_pkg::SUM_W-1:0]   acc_ff;
   logic signed [dga_pkg::SUM_W-1:0]   acc_in;

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= dga_pkg::PROD_W'(operand) * dga_pkg::PROD_W'(weight);
      end
   end

   // round half up, then floor shift
   assign prod_rnd = prod_ff + dga_pkg::HALF_LSB;
   assign total    = dga_pkg::sat_acc(acc_ff, prod_rnd[dga_pkg::PROD_W-1:dga_pkg::FRAC_W]);

   always_comb begin
      acc_in = acc_ff;
      if (ctl.valid) begin
         acc_in = ctl.last ? '0 : total;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

endmodule

@@ sv/dga_square.sv @@
// pipelined square of one gradient, q36.27 rounded half up, saturated to 63 bits
module dga_square (
   input  logic                                clock,
   input  logic signed [dga_pkg::SUM_W-1:0]    grad,
   output logic [dga_pkg::GAMMA_W-1:0]         square
);

   localparam int LO_W = dga_pkg::FRAC_W;
   localparam int HI_W = dga_pkg::HI_W;

   logic [dga_pkg::SUM_W-1:0]   mag;
   logic                        big_ff;
   logic [HI_W-1:0]             hi_ff;
   logic [LO_W-1:0]             lo_ff;
   logic                        big2_ff;
   logic [2*HI_W-1:0]           hh_ff;
   logic [HI_W+LO_W-1:0]        hl_ff;
   logic [2*LO_W-1:0]           ll_ff;
   logic [2*LO_W:0]             ll_rnd;
   logic [dga_pkg::GAMMA_W:0]   sq_wide;
   logic [dga_pkg::GAMMA_W-1:0] sq_ff;

   assign mag = grad[dga_pkg::SUM_W-1] ? (~grad + 1'b1) : grad;

   always_ff @(posedge clock) begin
      big_ff <= |mag[dga_pkg::SUM_W-1:dga_pkg::MAG_W];
      hi_ff  <= mag[dga_pkg::MAG_W-1:LO_W];
      lo_ff  <= mag[LO_W-1:0];
   end

   // three partial products of the split magnitude
   always_ff @(posedge clock) begin
      big2_ff <= big_ff;
      hh_ff   <= (2*HI_W)'(hi_ff) * (2*HI_W)'(hi_ff);
      hl_ff   <= (HI_W+LO_W)'(hi_ff) * (HI_W+LO_W)'(lo_ff);
      ll_ff   <= (2*LO_W)'(lo_ff) * (2*LO_W)'(lo_ff);
   end

   assign ll_rnd  = (2*LO_W+1)'(ll_ff) + ((2*LO_W+1)'(1) << (LO_W - 1));
   assign sq_wide = ((dga_pkg::GAMMA_W+1)'(hh_ff) << LO_W)
                  + ((dga_pkg::GAMMA_W+1)'(hl_ff) << 1)
                  + (dga_pkg::GAMMA_W+1)'(ll_rnd[2*LO_W:LO_W]);

   always_ff @(posedge clock) begin
      if (big2_ff || sq_wide[dga_pkg::GAMMA_W]) begin
         sq_ff <= '1;
      end else begin
         sq_ff <= sq_wide[dga_pkg::GAMMA_W-1:0];
      end
   end

   assign square = sq_ff;

endmodule

@@ sv/dga_merge.sv @@
// merging stage: scales the lane sums and forms the squared gradient norm
module dga_merge (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic                                mode,
   input  logic signed [dga_pkg::SUM_W-1:0]    sums [dga_pkg::LANE_CNT],
   input  logic                                take,
   output logic                                done,
   output dga_pkg::result_type                 result
);

   localparam int DEPTH = 5;

   logic signed [dga_pkg::SUM_W-1:0] sum_ff [dga_pkg::LANE_CNT];
   logic                             mode_ff;
   logic [DEPTH-1:0]                 stage_ff;
   logic                             done_ff;
   logic signed [dga_pkg::SUM_W-1:0] den_ff;
   logic signed [dga_pkg::SUM_W-1:0] gx_ff;
   logic signed [dga_pkg::SUM_W-1:0] gy_ff;
   logic signed [dga_pkg::SUM_W-1:0] gz_ff;
   logic [dga_pkg::GAMMA_W-1:0]      sq_x;
   logic [dga_pkg::GAMMA_W-1:0]      sq_y;
   logic [dga_pkg::GAMMA_W-1:0]      sq_z;
   logic [dga_pkg::GAMMA_W+1:0]      gamma_wide;
   logic [dga_pkg::GAMMA_W-1:0]      gamma_ff;

   always_ff @(posedge clock) begin
      if (start) begin
         sum_ff  <= sums;
         mode_ff <= mode;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_ff[0]) begin
         den_ff <= dga_pkg::sat_scale2(sum_ff[dga_pkg::LANE_DEN]);
         gx_ff  <= mode_ff ? dga_pkg::sat_scale4(sum_ff[dga_pkg::LANE_GX]) : '0;
         gy_ff  <= mode_ff ? dga_pkg::sat_scale4(sum_ff[dga_pkg::LANE_GY]) : '0;
         gz_ff  <= mode_ff ? dga_pkg::sat_scale4(sum_ff[dga_pkg::LANE_GZ]) : '0;
      end
   end

   dga_square u_sq_x (.clock(clock), .grad(gx_ff), .square(sq_x));
   dga_square u_sq_y (.clock(clock), .grad(gy_ff), .square(sq_y));
   dga_square u_sq_z (.clock(clock), .grad(gz_ff), .square(sq_z));

   assign gamma_wide = (dga_pkg::GAMMA_W+2)'(sq_x) + (dga_pkg::GAMMA_W+2)'(sq_y)
                     + (dga_pkg::GAMMA_W+2)'(sq_z);

   always_ff @(posedge clock) begin
      if (stage_ff[DEPTH-1]) begin
         gamma_ff <= (|gamma_wide[dga_pkg::GAMMA_W+1:dga_pkg::GAMMA_W]) ? '1
                   : gamma_wide[dga_pkg::GAMMA_W-1:0];
      end
   end

   // one point in flight; the scaled values hold until the result is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         stage_ff <= {stage_ff[DEPTH-2:0], start};
         if (stage_ff[DEPTH-1]) begin
            done_ff <= 1'b1;
         end else if (take) begin
            done_ff <= 1'b0;
         end
      end
   end

   assign done           = done_ff;
   assign result.density = den_ff;
   assign result.grad_x  = gx_ff;
   assign result.grad_y  = gy_ff;
   assign result.grad_z  = gz_ff;
   assign result.gamma   = gamma_ff;

endmodule

@@ sv/density_gradient_accumulator.sv @@
// top level: four multiply-accumulate lanes, merging stage and result register
//
// req carries one basis-function item per handshake; the item with last_basis set
// closes a grid point. Four lanes (density, x, y, z) each take one item per cycle:
// a registered 32x32 product, then a rounded, saturating add into a 48-bit sum.
// On the closing item the sums pass to the merging stage and the lanes clear.
// rsp carries one result per grid point: density = 2*sum, gradients = 4*sums and
// their squared norm; with gradient_mode clear the gradients and norm are zero.
// csr_write_enable writes gradient_mode from csr_write_data; reset sets it to 1.
// The closing item passes the lane product register, the merging stage's sum
// register, scaling, split squares over three stages and the final sum before its
// result enters the output register. Items that do not close a point go at one
// per cycle; after a closing item req.ready stays low until its result enters the
// output register, so the next point is not taken in before then.
// While the receiver stalls, one result waits in the output register and the next
// run is taken in; its result then waits until the register frees.
// Reset (synchronous) clears the lane sums, pipeline control and output valid flag.
module density_gradient_accumulator (
   input  logic    clock,
   input  logic    reset,
   dga_req_if.sink   req,
   dga_rsp_if.source rsp,
   input  logic    csr_write_enable,
   input  logic    csr_write_data
);

   logic                             accept;
   logic                             mode_ff;
   logic                             pending_ff;
   dga_pkg::lane_ctl_type            a_ctl_ff;
   logic signed [dga_pkg::VAL_W-1:0] lane_operand [dga_pkg::LANE_CNT];
   logic signed [dga_pkg::SUM_W-1:0] lane_total [dga_pkg::LANE_CNT];
   logic                             merge_done;
   dga_pkg::result_type              merge_result;
   logic                             load_out;
   logic                             rsp_valid_ff;
   dga_pkg::result_type              rsp_data_ff;

   assign accept    = req.valid && req.ready;
   assign req.ready = !pending_ff;
   assign load_out  = merge_done && (!rsp_valid_ff || rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b1;
      end else if (csr_write_enable) begin
         mode_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff     <= 1'b0;
         a_ctl_ff.valid <= 1'b0;
         a_ctl_ff.last  <= 1'b0;
      end else begin
         a_ctl_ff.valid <= accept;
         a_ctl_ff.last  <= req.last_basis;
         if (accept && req.last_basis) begin
            pending_ff <= 1'b1;
         end else if (load_out) begin
            pending_ff <= 1'b0;
         end
      end
   end

   assign lane_operand[dga_pkg::LANE_DEN] = req.basis_value;
   assign lane_operand[dga_pkg::LANE_GX]  = req.basis_grad_x;
   assign lane_operand[dga_pkg::LANE_GY]  = req.basis_grad_y;
   assign lane_operand[dga_pkg::LANE_GZ]  = req.basis_grad_z;

   for (genvar i = 0; i < dga_pkg::LANE_CNT; i++) begin : g_lane
      dga_lane u_lane (
         .clock   (clock),
         .reset   (reset),
         .load    (accept),
         .ctl     (a_ctl_ff),
         .operand (lane_operand[i]),
         .weight  (req.matrix_product),
         .total   (lane_total[i])
      );
   end

   dga_merge u_merge (
      .clock  (clock),
      .reset  (reset),
      .start  (a_ctl_ff.valid && a_ctl_ff.last),
      .mode   (mode_ff),
      .sums   (lane_total),
      .take   (load_out),
      .done   (merge_done),
      .result (merge_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_data_ff <= merge_result;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.density        = rsp_data_ff.density;
   assign rsp.density_grad_x = rsp_data_ff.grad_x;
   assign rsp.density_grad_y = rsp_data_ff.grad_y;
   assign rsp.density_grad_z = rsp_data_ff.grad_z;
   assign rsp.grad_norm_sq   = rsp_data_ff.gamma;

   // a result only appears for a point that was closed
   a_rsp_from_point: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(pending_ff))
      else $error("result without a closed point");

   // a closing item holds off further input
   a_close_stalls: assert property (@(posedge clock) disable iff (reset)
      accept && req.last_basis |=> !req.ready)
      else $error("input taken after closing item");

   // merging only finishes while a point is outstanding
   a_merge_pending: assert property (@(posedge clock) disable iff (reset)
      $rose(merge_done) |-> pending_ff)
      else $error("merge finished with no point outstanding");

endmodule
